// ===== hw/rtl/lbc_pkg.sv =====
// ----------------------------------------------------------------------------
// lbc_pkg: shared types and helpers of the layer blend compositor
// Pixel, request and configuration types, code enums and small helpers
// used by the compositor datapath, its register file and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package lbc_pkg;

    // Default scanline width in pixels.
    localparam int LINE_WIDTH_DEF = 240;

    // Layer number of the backdrop.
    localparam logic [2:0] LAYER_BACKDROP = 3'd5;
    // Highest layer number that is subject to the window masks.
    localparam logic [2:0] LAYER_LAST_WIN = 3'd4;
    // Window mask bit that allows color effects.
    localparam int WIN_BLEND_BIT = 5;
    // Largest weight that the effects accept.
    localparam logic [4:0] COEF_MAX = 5'd16;
    // Largest 5-bit channel value.
    localparam logic [4:0] CHAN_MAX = 5'd31;

    // Request operations.
    typedef enum logic {
        OP_INIT  = 1'b0,
        OP_MERGE = 1'b1
    } t_op;

    // Color effect modes.
    typedef enum logic [1:0] {
        MODE_OFF      = 2'd0,
        MODE_ALPHA    = 2'd1,
        MODE_BRIGHTEN = 2'd2,
        MODE_DARKEN   = 2'd3
    } t_mode;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_BLEND_MODE    = 3'd0,
        REG_BLEND_TARGETS = 3'd1,
        REG_ALPHA_TOP     = 3'd2,
        REG_ALPHA_BOTTOM  = 3'd3,
        REG_FADE_COEF     = 3'd4,
        REG_WINDOWS_ON    = 3'd5,
        REG_FORCED_BLANK  = 3'd6
    } t_reg_idx;

    // Width of the configuration write data.
    localparam int CFG_DATA_W = 16;

    // One stored pixel: layer, visible flag and 5-bit channels.
    typedef struct packed {
        logic [2:0] layer;
        logic       vis;
        logic [4:0] blue;
        logic [4:0] green;
        logic [4:0] red;
    } t_pixel;

    localparam int PIXEL_W = $bits(t_pixel);

    // Input request.
    typedef struct packed {
        t_op        operation;
        logic [7:0] column;
        logic [4:0] red_in;
        logic [4:0] green_in;
        logic [4:0] blue_in;
        logic       pixel_visible;
        logic       sprite_semi;
        logic [2:0] layer_id;
        logic [5:0] window_mask;
    } t_in_item;

    // Result request.
    typedef struct packed {
        logic [7:0] column_out;
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [2:0] top_layer;
    } t_out_item;

    // Configuration register contents.
    typedef struct packed {
        t_mode       blend_mode;
        logic [13:0] blend_targets;
        logic [4:0]  alpha_top_coef;
        logic [4:0]  alpha_bottom_coef;
        logic [4:0]  fade_coef;
        logic        windows_on;
        logic        forced_blank;
    } t_cfg;

    // Limit a weight to 16.
    function automatic logic [4:0] clamp16(input logic [4:0] v);
        return (v > COEF_MAX) ? COEF_MAX : v;
    endfunction

    // Widen a 5-bit channel to 8 bits by repeating its high bits.
    function automatic logic [7:0] expand5(input logic [4:0] c);
        return {c, c[4:2]};
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/layer_blend_compositor.sv =====
// ----------------------------------------------------------------------------
// layer_blend_compositor: per-pixel layer compositor for one scanline
// Input requests (init a column with the backdrop, or merge a layer pixel)
// come in on a valid/stall channel. Each request yields one result request
// with the column's current color at 8 bits per channel and the layer that
// owns it. The user must write the configuration registers, on a separate
// valid/ready port, only while no request is in flight; nothing enforces it.
//
// An accepted request passes through the second stage and the result
// register, which drives the result channel. Throughput: one request per
// cycle while the receiver does not stall. Each request reads the lower
// and result stores of its column when it is accepted and writes both back
// as it leaves the second stage; a request to the same column as its
// predecessor takes the forwarded pixels instead of the stale read.
// When the receiver stalls, the result register holds its request and the
// second stage holds its own; the input is stalled once both are full.
// Reset clears the configuration registers and all valid flags; the line
// stores are not cleared and each column must be initialized before it is
// merged.
// ----------------------------------------------------------------------------
`default_nettype none

module layer_blend_compositor
    import lbc_pkg::*;
#(
    parameter int LINE_WIDTH = LINE_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_in_item              i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_out_item                  o_out_data,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [2:0]            i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW = (LINE_WIDTH > 1) ? $clog2(LINE_WIDTH) : 1;

    t_cfg       cfg;
    logic       in_acc;
    logic       s1_adv;
    logic       s1_we;
    logic       s1_in_range;
    logic [AW+7:0] in_col_ext;
    logic [AW+7:0] s1_col_ext;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [PIXEL_W-1:0] lower_rdata;
    logic [PIXEL_W-1:0] result_rdata;
    t_pixel     lower_cur;
    t_pixel     result_cur;
    t_pixel     lower_new;
    t_pixel     result_new;

    logic       r_s1_valid;
    t_in_item   r_s1_item;
    logic       r_s1_fwd;
    t_pixel     r_fwd_lower;
    t_pixel     r_fwd_result;
    logic       r_out_valid;
    t_out_item  r_out_item;
    t_out_item  n_out_item;

    // Configuration registers.
    lbc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Handshake: the second stage moves on when the result register is free.
    assign s1_adv     = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign in_acc     = i_in_valid && !o_in_stall;

    // Column to store address and range check.
    assign in_col_ext  = {{AW{1'b0}}, i_in_data.column};
    assign s1_col_ext  = {{AW{1'b0}}, r_s1_item.column};
    assign rd_addr     = in_col_ext[AW-1:0];
    assign wr_addr     = s1_col_ext[AW-1:0];
    assign s1_in_range = s1_col_ext < (AW+8)'(LINE_WIDTH);
    assign s1_we       = r_s1_valid && s1_adv && s1_in_range;

    // Lower-layer store and result store.
    lbc_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (LINE_WIDTH)
    ) u_lower_ram (
        .i_clk   (i_clk),
        .i_we    (s1_we),
        .i_waddr (wr_addr),
        .i_wdata (lower_new),
        .i_re    (in_acc),
        .i_raddr (rd_addr),
        .o_rdata (lower_rdata)
    );

    lbc_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (LINE_WIDTH)
    ) u_result_ram (
        .i_clk   (i_clk),
        .i_we    (s1_we),
        .i_waddr (wr_addr),
        .i_wdata (result_new),
        .i_re    (in_acc),
        .i_raddr (rd_addr),
        .o_rdata (result_rdata)
    );

    // Use the pixels written by the previous request when it hit this column.
    assign lower_cur  = r_s1_fwd ? r_fwd_lower  : t_pixel'(lower_rdata);
    assign result_cur = r_s1_fwd ? r_fwd_result : t_pixel'(result_rdata);

    // Merge datapath.
    lbc_blend u_blend (
        .i_cfg    (cfg),
        .i_item   (r_s1_item),
        .i_lower  (lower_cur),
        .i_result (result_cur),
        .o_lower  (lower_new),
        .o_result (result_new)
    );

    // Result request; out-of-range columns report black, layer 0.
    always_comb begin
        n_out_item.column_out = r_s1_item.column;
        if (s1_in_range) begin
            n_out_item.red_out   = expand5(result_new.red);
            n_out_item.green_out = expand5(result_new.green);
            n_out_item.blue_out  = expand5(result_new.blue);
            n_out_item.top_layer = result_new.layer;
        end else begin
            n_out_item.red_out   = '0;
            n_out_item.green_out = '0;
            n_out_item.blue_out  = '0;
            n_out_item.top_layer = '0;
        end
    end

    // Pipeline control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // Pipeline payload and forwarding registers.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_item    <= i_in_data;
            r_s1_fwd     <= s1_we && (i_in_data.column == r_s1_item.column);
            r_fwd_lower  <= lower_new;
            r_fwd_result <= result_new;
        end
        if (s1_adv && r_s1_valid) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

endmodule

`default_nettype wire

// ===== hw/rtl/lbc_ram.sv =====
// ----------------------------------------------------------------------------
// lbc_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; the read data is registered and
// holds while no read is enabled. A read of the address being written
// returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module lbc_ram #(
    parameter int WIDTH = 19,
    parameter int DEPTH = 240,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hw/rtl/lbc_cfg.sv =====
// ----------------------------------------------------------------------------
// lbc_cfg: configuration register file of the compositor
// Holds the effect mode, target masks, weights and window and blank
// flags. Writes are taken in every cycle; unknown indexes are ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module lbc_cfg
    import lbc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [2:0]            i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Decode a register write.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_BLEND_MODE:    n_cfg.blend_mode        = t_mode'(i_cfg_data[1:0]);
                REG_BLEND_TARGETS: n_cfg.blend_targets     = i_cfg_data[13:0];
                REG_ALPHA_TOP:     n_cfg.alpha_top_coef    = i_cfg_data[4:0];
                REG_ALPHA_BOTTOM:  n_cfg.alpha_bottom_coef = i_cfg_data[4:0];
                REG_FADE_COEF:     n_cfg.fade_coef         = i_cfg_data[4:0];
                REG_WINDOWS_ON:    n_cfg.windows_on        = i_cfg_data[0];
                REG_FORCED_BLANK:  n_cfg.forced_blank      = i_cfg_data[0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    // Register state, cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

endmodule

`default_nettype wire

// ===== hw/rtl/lbc_blend.sv =====
// ----------------------------------------------------------------------------
// lbc_blend: pixel merge datapath of the compositor
// From a request and the column's stored lower and result pixels, works
// out the new lower and result pixels: backdrop init, window tests,
// alpha blend with saturation, brighten and darken.
// ----------------------------------------------------------------------------
`default_nettype none

module lbc_blend
    import lbc_pkg::*;
(
    input  wire t_cfg     i_cfg,
    input  wire t_in_item i_item,
    input  wire t_pixel   i_lower,
    input  wire t_pixel   i_result,
    output t_pixel        o_lower,
    output t_pixel        o_result
);

    logic       is_init;
    logic [4:0] top_chan [3];
    logic [4:0] bot_chan [3];
    logic [4:0] out_chan [3];
    logic [9:0] prod_top [3];
    logic [9:0] prod_bot [3];
    logic [10:0] alpha_sum [3];
    logic [9:0] fade_up  [3];
    logic [9:0] fade_dn  [3];
    t_pixel     bd_px;
    t_pixel     top_px;
    t_pixel     bot_px;
    t_pixel     merged_px;
    logic [2:0] layer;
    logic       vis;
    logic       fb;
    logic       win_test;
    logic       hidden;
    logic       bot_en;
    logic       top_bit;
    logic       alpha_ok;
    t_mode      mode;
    logic [4:0] eva;
    logic [4:0] evb;
    logic [4:0] evy;
    logic [7:0] first_tgt;
    logic [7:0] second_tgt;
    logic [7:0] win_bits;

    assign is_init = (i_item.operation == OP_INIT);
    assign eva     = clamp16(i_cfg.alpha_top_coef);
    assign evb     = clamp16(i_cfg.alpha_bottom_coef);
    assign evy     = clamp16(i_cfg.fade_coef);

    // Target masks over all eight layer codes; missing bits read as zero.
    assign first_tgt  = i_cfg.blend_targets[7:0];
    assign second_tgt = {2'b00, i_cfg.blend_targets[13:8]};
    assign win_bits   = {2'b00, i_item.window_mask};

    // Backdrop color, white under forced blank.
    always_comb begin
        bd_px.layer = LAYER_BACKDROP;
        bd_px.vis   = 1'b1;
        bd_px.red   = i_cfg.forced_blank ? CHAN_MAX : i_item.red_in;
        bd_px.green = i_cfg.forced_blank ? CHAN_MAX : i_item.green_in;
        bd_px.blue  = i_cfg.forced_blank ? CHAN_MAX : i_item.blue_in;
    end

    // An init request merges the backdrop over itself as layer 5.
    assign layer  = is_init ? LAYER_BACKDROP : i_item.layer_id;
    assign vis    = is_init ? 1'b1 : i_item.pixel_visible;
    assign fb     = is_init ? 1'b0 : i_item.sprite_semi;
    assign bot_px = is_init ? bd_px : i_lower;

    always_comb begin
        top_px.layer = layer;
        top_px.vis   = 1'b1;
        top_px.red   = is_init ? bd_px.red   : i_item.red_in;
        top_px.green = is_init ? bd_px.green : i_item.green_in;
        top_px.blue  = is_init ? bd_px.blue  : i_item.blue_in;
    end

    // Window and target tests, and the mode that applies.
    assign win_test = !is_init && (layer <= LAYER_LAST_WIN) && i_cfg.windows_on;
    assign hidden   = !vis || (win_test && !win_bits[layer]);
    assign bot_en   = second_tgt[bot_px.layer];
    assign top_bit  = first_tgt[layer];
    assign alpha_ok = (top_bit || fb) && bot_en && bot_px.vis;

    always_comb begin
        mode = i_cfg.blend_mode;
        if (win_test && !i_item.window_mask[WIN_BLEND_BIT]) begin
            mode = MODE_OFF;
        end
        if (fb && bot_en) begin
            mode = MODE_ALPHA;
        end
    end

    // Per-channel effect arithmetic.
    assign top_chan[0] = top_px.red;
    assign top_chan[1] = top_px.green;
    assign top_chan[2] = top_px.blue;
    assign bot_chan[0] = bot_px.red;
    assign bot_chan[1] = bot_px.green;
    assign bot_chan[2] = bot_px.blue;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            prod_top[k]  = 10'(top_chan[k]) * 10'(eva);
            prod_bot[k]  = 10'(bot_chan[k]) * 10'(evb);
            alpha_sum[k] = 11'(prod_top[k]) + 11'(prod_bot[k]);
            fade_up[k]   = 10'(CHAN_MAX - top_chan[k]) * 10'(evy);
            fade_dn[k]   = 10'(top_chan[k]) * 10'(evy);
            out_chan[k]  = top_chan[k];
            case (mode)
                MODE_ALPHA: begin
                    if (alpha_ok) begin
                        out_chan[k] = (alpha_sum[k][10:4] > 7'(CHAN_MAX)) ?
                                      CHAN_MAX : alpha_sum[k][8:4];
                    end
                end
                MODE_BRIGHTEN: begin
                    if (top_bit) begin
                        out_chan[k] = top_chan[k] + fade_up[k][8:4];
                    end
                end
                MODE_DARKEN: begin
                    if (top_bit) begin
                        out_chan[k] = top_chan[k] - fade_dn[k][8:4];
                    end
                end
                default: out_chan[k] = top_chan[k];
            endcase
        end
    end

    always_comb begin
        merged_px.layer = layer;
        merged_px.vis   = 1'b1;
        merged_px.red   = out_chan[0];
        merged_px.green = out_chan[1];
        merged_px.blue  = out_chan[2];
    end

    // Select the pixels to store back.
    always_comb begin
        if (is_init) begin
            if (i_cfg.blend_mode == MODE_BRIGHTEN || i_cfg.blend_mode == MODE_DARKEN) begin
                o_lower  = bd_px;
                o_result = merged_px;
            end else begin
                o_lower  = '0;
                o_result = bd_px;
            end
        end else if (hidden) begin
            o_lower  = i_lower;
            o_result = i_result;
        end else begin
            o_lower  = top_px;
            o_result = merged_px;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/lbc_checker.sv =====
// ----------------------------------------------------------------------------
// lbc_checker: port-level checks of the layer blend compositor
// Watches the request channels and checks result hold under stall, the
// advance into the result register and the report of out-of-range columns.
// ----------------------------------------------------------------------------
`default_nettype none

module lbc_checker
    import lbc_pkg::*;
#(
    parameter int LINE_WIDTH = LINE_WIDTH_DEF
) (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_stall,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_item o_out_data
);

    // A stalled result request stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result request dropped while stalled");

    // A stalled result request keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out_data))
        else $error("result payload changed while stalled");

    // An accepted request is loaded into the result register as it leaves the
    // read stage, if that register is free to load.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) ##1 (!o_out_valid || !i_out_stall)
        |=> o_out_valid)
        else $error("accepted request did not reach the result register");

    // Columns beyond the line report black owned by layer 0.
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (32'(o_out_data.column_out) >= LINE_WIDTH)) |->
        (o_out_data.red_out == 8'd0 && o_out_data.green_out == 8'd0 &&
         o_out_data.blue_out == 8'd0 && o_out_data.top_layer == 3'd0))
        else $error("out-of-range column reported a color");

endmodule

bind layer_blend_compositor lbc_checker #(.LINE_WIDTH(LINE_WIDTH)) u_lbc_checker (.*);

`default_nettype wire
